>>> rtl/pmid_pkg.sv
// Shared constants and types for the periodic minimum-image distance unit.
package pmid_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int CFG_INDEX_BITS = 1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_BOX_LENGTH      = 1'b0,
		CFG_PERIODIC_ENABLE = 1'b1
	} cfg_index_t;

endpackage

>>> rtl/periodic_min_image_distance_3d_unit.sv
// Top level: stream ports, configuration registers and the distance pipeline.
// Pipeline: two stages of axis difference and minimum image, one of squaring, one of
// summing, and one per root bit in the square-root pipeline, whose last stage is the
// output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: clears all valid bits; box_length to all ones, periodic_enable to 1.
module periodic_min_image_distance_3d_unit #(
	parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z
	input  logic [((6*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// dist_squared, distance
	output logic [((3*COORD_BITS+3+7)/8)*8-1:0]  m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pmid_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data
);

	localparam int OUT_W = ((3 * COORD_BITS + 3 + 7) / 8) * 8;
	localparam int SUM_W = 2 * COORD_BITS + 2;

	logic [COORD_BITS-1:0]      box_length_q;
	logic                       periodic_enable_q;
	logic                       ce;
	logic [2:0][COORD_BITS-1:0] first;
	logic [2:0][COORD_BITS-1:0] second;
	logic                       axis_valid;
	logic [2:0][COORD_BITS-1:0] axis_term;
	logic                       sum_valid;
	logic [SUM_W-1:0]           sum;
	logic                       root_valid;
	logic [SUM_W-1:0]           dist_squared;
	logic [COORD_BITS:0]        distance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_length_q      <= '1;
			periodic_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			case (pmid_pkg::cfg_index_t'(cfg_index))
				pmid_pkg::CFG_BOX_LENGTH:      box_length_q      <= cfg_data;
				pmid_pkg::CFG_PERIODIC_ENABLE: periodic_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance everything when the output stage is empty or being drained
	assign ce       = !root_valid || m_tready;
	assign s_tready = ce;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			first[i]  = s_tdata[i*COORD_BITS +: COORD_BITS];
			second[i] = s_tdata[(i+3)*COORD_BITS +: COORD_BITS];
		end
	end

	pmid_axis #(.COORD_BITS(COORD_BITS)) u_axis (
		.clk             (clk),
		.arst_n          (arst_n),
		.ce              (ce),
		.valid_in        (s_tvalid),
		.first           (first),
		.second          (second),
		.box_length      (box_length_q),
		.periodic_enable (periodic_enable_q),
		.valid_out       (axis_valid),
		.term            (axis_term)
	);

	pmid_sqsum #(.COORD_BITS(COORD_BITS)) u_sqsum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.valid_in  (axis_valid),
		.term      (axis_term),
		.valid_out (sum_valid),
		.sum       (sum)
	);

	pmid_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
		.clk          (clk),
		.arst_n       (arst_n),
		.ce           (ce),
		.valid_in     (sum_valid),
		.radicand     (sum),
		.valid_out    (root_valid),
		.radicand_out (dist_squared),
		.root         (distance)
	);

	assign m_tvalid = root_valid;
	assign m_tdata  = OUT_W'({distance, dist_squared});

endmodule

>>> rtl/pmid_axis.sv
// Per-axis absolute difference and minimum-image selection, two stages.
module pmid_axis #(
	parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       valid_in,
	input  logic [2:0][COORD_BITS-1:0] first,
	input  logic [2:0][COORD_BITS-1:0] second,
	input  logic [COORD_BITS-1:0]      box_length,
	input  logic                       periodic_enable,
	output logic                       valid_out,
	output logic [2:0][COORD_BITS-1:0] term
);

	logic                       vld_s1;
	logic                       vld_s2;
	logic [2:0][COORD_BITS-1:0] d_s1;
	logic [2:0][COORD_BITS-1:0] m_s2;
	logic [2:0][COORD_BITS-1:0] d_next;
	logic [2:0][COORD_BITS-1:0] m_next;
	logic [2:0][COORD_BITS-1:0] alt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_next[i] = (first[i] > second[i]) ? (first[i] - second[i]) : (second[i] - first[i]);
			alt[i]    = (box_length > d_s1[i]) ? (box_length - d_s1[i]) : (d_s1[i] - box_length);
			if (periodic_enable && (alt[i] < d_s1[i])) begin
				m_next[i] = alt[i];
			end else begin
				m_next[i] = d_s1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= valid_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_s1 <= d_next;
			m_s2 <= m_next;
		end
	end

	assign valid_out = vld_s2;
	assign term      = m_s2;

endmodule

>>> rtl/pmid_sqsum.sv
// Squares of the three axis terms and their exact sum, two stages.
module pmid_sqsum #(
	parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ce,
	input  logic                       valid_in,
	input  logic [2:0][COORD_BITS-1:0] term,
	output logic                       valid_out,
	output logic [2*COORD_BITS+1:0]    sum
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = 2 * COORD_BITS + 2;

	logic                 vld_s3;
	logic                 vld_s4;
	logic [2:0][SQ_W-1:0] sq_s3;
	logic [SUM_W-1:0]     sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ce) begin
			vld_s3 <= valid_in;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= SQ_W'(term[i] * term[i]);
			end
			sum_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
		end
	end

	assign valid_out = vld_s4;
	assign sum       = sum_s4;

endmodule

>>> rtl/pmid_sqrt.sv
// Restoring integer square root, one root bit per pipeline stage.
module pmid_sqrt #(
	parameter int COORD_BITS = pmid_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ce,
	input  logic                    valid_in,
	input  logic [2*COORD_BITS+1:0] radicand,
	output logic                    valid_out,
	output logic [2*COORD_BITS+1:0] radicand_out,
	output logic [COORD_BITS:0]     root
);

	localparam int RB   = COORD_BITS + 1;
	localparam int RADW = 2 * RB;
	localparam int RW   = RB + 3;

	logic            vld_s  [RB];
	logic [RW-1:0]   rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	logic [RADW-1:0] dsq_s  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_step
		localparam int LO = 2 * (RB - 1 - k);

		logic            v_prev;
		logic [RW-1:0]   rem_prev;
		logic [RB-1:0]   root_prev;
		logic [RADW-1:0] dsq_prev;
		logic [RW-1:0]   rem_cat;
		logic [RW-1:0]   trial;
		logic            take;

		if (k == 0) begin : g_first
			assign v_prev    = valid_in;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign dsq_prev  = radicand;
		end else begin : g_next
			assign v_prev    = vld_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
			assign dsq_prev  = dsq_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_cat = {rem_prev[RW-3:0], dsq_prev[LO+1:LO]};
		assign trial   = RW'({root_prev, 2'b01});
		assign take    = (rem_cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ce) begin
				vld_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k]  <= take ? (rem_cat - trial) : rem_cat;
				root_s[k] <= {root_prev[RB-2:0], take};
				dsq_s[k]  <= dsq_prev;
			end
		end
	end

	assign valid_out    = vld_s[RB-1];
	assign radicand_out = dsq_s[RB-1];
	assign root         = root_s[RB-1];

endmodule
